// ----- src/lpn_pkg.sv -----
// Shared constants and sequencer state type for the lexical path normalizer.
package lpn_pkg;

    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] NUL_CHAR   = 8'h00;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_BYTE_WR,
        ST_CLOSE,
        ST_POP_RD,
        ST_POP_CHK,
        ST_FIN,
        ST_EMIT,
        ST_EMIT_RD,
        ST_EMIT_LD
    } lpn_state_t;

endpackage

// ----- src/lpn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lpn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/lexical_path_normalizer.sv -----
// Top level of the lexical path normalizer: byte sequencer around one path RAM.
//
// Accepts path spelling bytes one word at a time and keeps an absolute,
// normalized path rooted at '/' in a PATH_BYTES-deep RAM; on a word with
// tlast the normalized path streams out one byte per word (tlast on the final
// byte, tuser 1), or a single error word (byte 0, tuser 0) after overflow.
// The sequencer walks the path RAM one address at a time through its one write
// port and its registered read port: a ".." component walks back over path
// bytes until a separator or the root, and the finishing word reads each
// emitted byte before loading it, holding while m_tready is low. s_tready is
// low while a word is in work. The last output word sits in its own register,
// so the next spelling is taken while it waits. No clearing pass is needed
// after reset.
module lexical_path_normalizer
    import lpn_pkg::*;
#(
    parameter int PATH_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic [1:0] s_tuser,   // [0] start_req, [1] join_req
    input  logic       s_tlast,   // finish
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] path_byte
    output logic [0:0] m_tuser,   // [0] ok
    output logic       m_tlast    // last
);

    localparam int AW = $clog2(PATH_BYTES);
    localparam int CW = $clog2(PATH_BYTES + 1);
    localparam int EW = AW + 2;

    lpn_state_t state_reg, state_next;

    logic [7:0]    ch_reg, ch_next;
    logic          fin_reg, fin_next;
    logic [AW-1:0] path_len_reg, path_len_next;
    logic [AW-1:0] comp_begin_reg, comp_begin_next;
    logic          in_comp_reg, in_comp_next;
    logic          overflow_reg, overflow_next;
    logic [CW-1:0] comp_count_reg, comp_count_next;
    logic          all_dots_reg, all_dots_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg, m_tdata_next;
    logic          m_tlast_reg, m_tlast_next;
    logic          m_ok_reg, m_ok_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          in_accept;
    logic          sep;
    logic [EW-1:0] comp_end;
    logic          pos_fits;
    logic          end_fits;
    logic          is_dot1;
    logic          is_dot2;
    logic          out_free;
    logic          emit_last;
    logic          byte_step;
    logic          close_done_idle;

    lpn_ram #(
        .WIDTH(8),
        .DEPTH(PATH_BYTES)
    ) u_path_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Shared position arithmetic: next byte slot and component end
    assign in_accept = s_tvalid && s_tready;
    assign sep       = (comp_begin_reg > AW'(1));
    assign comp_end  = EW'(comp_begin_reg) + EW'(sep) + EW'(comp_count_reg);
    assign pos_fits  = (comp_end < EW'(PATH_BYTES));
    assign end_fits  = (comp_end <= EW'(PATH_BYTES - 1));
    assign is_dot1   = all_dots_reg && (comp_count_reg == CW'(1));
    assign is_dot2   = all_dots_reg && (comp_count_reg == CW'(2));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_last = ({1'b0, idx_reg} + (AW + 1)'(1)) == {1'b0, path_len_reg};
    assign byte_step = !overflow_reg && (ch_reg != SLASH_CHAR) && (ch_reg != NUL_CHAR);
    assign close_done_idle = !fin_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (!overflow_reg && ch_reg == SLASH_CHAR)
                begin
                    state_next = ST_CLOSE;
                end
                else if (byte_step && !in_comp_reg)
                begin
                    state_next = ST_BYTE_WR;
                end
                else
                begin
                    state_next = fin_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_BYTE_WR:
            begin
                state_next = fin_reg ? ST_FIN : ST_IDLE;
            end
            ST_CLOSE:
            begin
                if (in_comp_reg && !is_dot1 && is_dot2)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = close_done_idle ? ST_IDLE : ST_EMIT;
                end
            end
            ST_POP_RD:
            begin
                if (path_len_reg > AW'(1))
                begin
                    state_next = ST_POP_CHK;
                end
                else
                begin
                    state_next = close_done_idle ? ST_IDLE : ST_EMIT;
                end
            end
            ST_POP_CHK:
            begin
                if (ram_rdata != SLASH_CHAR)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = close_done_idle ? ST_IDLE : ST_EMIT;
                end
            end
            ST_FIN:
            begin
                state_next = (!overflow_reg && in_comp_reg) ? ST_CLOSE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!overflow_reg)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and output word
    always_comb
    begin
        ch_next         = ch_reg;
        fin_next        = fin_reg;
        path_len_next   = path_len_reg;
        comp_begin_next = comp_begin_reg;
        in_comp_next    = in_comp_reg;
        overflow_next   = overflow_reg;
        comp_count_next = comp_count_reg;
        all_dots_next   = all_dots_reg;
        idx_next        = idx_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        m_ok_next       = m_ok_reg;
        ram_we          = 1'b0;
        ram_waddr       = comp_end[AW-1:0];
        ram_wdata       = ch_reg;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // Latch the word and apply a start: restart at root or keep the joined path
                if (in_accept)
                begin
                    ch_next  = s_tdata;
                    fin_next = s_tlast;
                    if (s_tuser[0])
                    begin
                        in_comp_next = 1'b0;
                        if (!(s_tuser[1] && s_tdata != SLASH_CHAR))
                        begin
                            path_len_next   = AW'(1);
                            comp_begin_next = '0;
                            overflow_next   = 1'b0;
                            comp_count_next = '0;
                            all_dots_next   = 1'b1;
                        end
                    end
                end
            end
            ST_STEP:
            begin
                if (byte_step)
                begin
                    if (!in_comp_reg)
                    begin
                        // Open a component, put its separator after a non-root path
                        in_comp_next    = 1'b1;
                        comp_begin_next = path_len_reg;
                        comp_count_next = '0;
                        all_dots_next   = 1'b1;
                        ram_we          = (path_len_reg > AW'(1));
                        ram_waddr       = path_len_reg;
                        ram_wdata       = SLASH_CHAR;
                    end
                    else
                    begin
                        ram_we          = pos_fits;
                        all_dots_next   = all_dots_reg && (ch_reg == DOT_CHAR);
                        if (comp_count_reg != CW'(PATH_BYTES))
                        begin
                            comp_count_next = comp_count_reg + CW'(1);
                        end
                    end
                end
            end
            ST_BYTE_WR:
            begin
                // Store the first byte of a fresh component
                ram_we        = pos_fits;
                all_dots_next = all_dots_reg && (ch_reg == DOT_CHAR);
                if (comp_count_reg != CW'(PATH_BYTES))
                begin
                    comp_count_next = comp_count_reg + CW'(1);
                end
            end
            ST_CLOSE:
            begin
                // End the open component: drop ".", pop on "..", else commit or flag overflow
                if (in_comp_reg)
                begin
                    in_comp_next = 1'b0;
                    if (!is_dot1 && !is_dot2)
                    begin
                        if (end_fits)
                        begin
                            path_len_next = comp_end[AW-1:0];
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                end
            end
            ST_POP_RD:
            begin
                ram_re    = (path_len_reg > AW'(1));
                ram_raddr = path_len_reg - AW'(1);
            end
            ST_POP_CHK:
            begin
                // Walk back one byte; a separator ends the pop and is dropped too
                path_len_next = path_len_reg - AW'(1);
            end
            ST_FIN:
            begin
                if (overflow_reg || !in_comp_reg)
                begin
                    in_comp_next = 1'b0;
                end
            end
            ST_EMIT:
            begin
                idx_next = '0;
                if (overflow_reg && out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = NUL_CHAR;
                    m_tlast_next  = 1'b1;
                    m_ok_next     = 1'b0;
                end
            end
            ST_EMIT_RD:
            begin
                ram_re = 1'b1;
            end
            ST_EMIT_LD:
            begin
                // Hand one path byte to the output register; entry 0 is always the root
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = (idx_reg == '0) ? SLASH_CHAR : ram_rdata;
                    m_tlast_next  = emit_last;
                    m_ok_next     = 1'b1;
                    idx_next      = idx_reg + AW'(1);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            path_len_reg   <= AW'(1);
            comp_begin_reg <= '0;
            in_comp_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
            comp_count_reg <= '0;
            all_dots_reg   <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            path_len_reg   <= path_len_next;
            comp_begin_reg <= comp_begin_next;
            in_comp_reg    <= in_comp_next;
            overflow_reg   <= overflow_next;
            comp_count_reg <= comp_count_next;
            all_dots_reg   <= all_dots_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        fin_reg     <= fin_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_ok_reg    <= m_ok_next;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_ok_reg;

    // Path length stays inside the buffer and never drops below the root
    assert property (@(posedge clk) disable iff (!rst_n)
        (path_len_reg != '0) && ({1'b0, path_len_reg} < (AW + 1)'(PATH_BYTES)))
        else $error("path length out of range");

    // An open component always begins at the committed path end
    assert property (@(posedge clk) disable iff (!rst_n)
        in_comp_reg |-> (comp_begin_reg == path_len_reg))
        else $error("open component detached from path end");

    // An error word is a single zero byte marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == NUL_CHAR))
        else $error("malformed error word");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the lexical path normalizer stream block.
`timescale 1ns / 100ps

module tb_top
    import lpn_pkg::*;
();

    localparam int PATH_BYTES   = 64;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int NUM_ROWS     = 29;
    localparam int PHASE_ITEMS  = 55;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One input word: path byte plus spelling flags
    typedef struct packed {
        logic [7:0] ch;
        logic       start;
        logic       joined;
        logic       fin;
    } path_item_t;

    // One output word: normalized path byte, end marker, status
    typedef struct packed {
        logic [7:0] pbyte;
        logic       last;
        logic       ok;
    } path_word_t;

    // Directed row: word repeated reps times, start on the first, finish on the last
    typedef struct packed {
        logic [7:0] ch;
        logic       start;
        logic       joined;
        logic       fin;
        logic [7:0] reps;
        logic       typed;
        logic [7:0] want_byte;
        logic       want_ok;
    } dir_row_t;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic [1:0] s_tuser  = '0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    // Normalizer shadow state
    logic [7:0] path_mem [PATH_BYTES];
    int         path_len;
    int         comp_start;
    int         comp_len;
    bit         comp_open;
    bit         comp_dots;
    bit         path_ovf;

    path_word_t next_words [PATH_BYTES];
    int         next_count;
    path_word_t path_expect [$];
    path_item_t spell_q [$];
    dir_row_t   directed_rows [NUM_ROWS];
    path_word_t head_word;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 1'b0;
    int  mismatches     = 0;
    int  items_sent     = 0;
    int  spellings_done = 0;
    int  words_checked  = 0;
    int  error_words    = 0;
    int  stall_cycles   = 0;

    lexical_path_normalizer #(
        .PATH_BYTES(PATH_BYTES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Return to the root and clear the overflow flag
    function void go_root();
        path_mem[0] = SLASH_CHAR;
        path_len    = 1;
        comp_start  = 0;
        comp_open   = 1'b0;
        path_ovf    = 1'b0;
        comp_len    = 0;
        comp_dots   = 1'b1;
    endfunction

    function int sep_len(int at);
        return (at > 1) ? 1 : 0;
    endfunction

    // Walk back over the last component and its separator
    function void pop_dir();
        while (path_len > 1 && path_mem[path_len - 1] != SLASH_CHAR)
            path_len--;
        if (path_len > 1)
            path_len--;
    endfunction

    function void append_char(logic [7:0] c);
        int pos;
        if (!comp_open)
        begin
            comp_open  = 1'b1;
            comp_start = path_len;
            comp_len   = 0;
            comp_dots  = 1'b1;
            if (sep_len(comp_start) != 0 && comp_start < PATH_BYTES)
                path_mem[comp_start] = SLASH_CHAR;
        end
        pos = comp_start + sep_len(comp_start) + comp_len;
        if (pos < PATH_BYTES)
            path_mem[pos] = c;
        if (c != DOT_CHAR)
            comp_dots = 1'b0;
        if (comp_len < PATH_BYTES)
            comp_len++;
    endfunction

    // Close the open component: drop ".", pop on "..", else commit if it fits or flag overflow
    function void close_comp();
        int tail;
        if (!comp_open)
            return;
        comp_open = 1'b0;
        if (comp_dots && comp_len == 1)
            return;
        if (comp_dots && comp_len == 2)
        begin
            pop_dir();
            return;
        end
        tail = comp_start + sep_len(comp_start) + comp_len;
        if (tail > PATH_BYTES - 1)
            path_ovf = 1'b1;
        else
            path_len = tail;
    endfunction

    // Advance the shadow path by one word; fill next_words on finish
    function void normalize_word(path_item_t it);
        next_count = 0;
        if (it.start)
        begin
            if (it.joined && it.ch != SLASH_CHAR)
                comp_open = 1'b0;
            else
                go_root();
        end
        if (!path_ovf)
        begin
            if (it.ch == SLASH_CHAR)
                close_comp();
            else if (it.ch != NUL_CHAR)
                append_char(it.ch);
        end
        if (!it.fin)
            return;
        if (!path_ovf)
            close_comp();
        comp_open = 1'b0;
        if (path_ovf)
        begin
            next_words[0] = '{8'h00, 1'b1, 1'b0};
            next_count    = 1;
            return;
        end
        for (int i = 0; i < path_len && i < PATH_BYTES; i++)
            next_words[i] = '{path_mem[i], (i + 1 == path_len), 1'b1};
        next_count = path_len;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 30)
            $display("[%0t] MISMATCH %s", $time, what);
        mismatches++;
    endtask

    // Offer one word, wait for the handshake, then queue what it should produce
    task automatic send_word(input path_item_t it, input bit typed, input path_word_t typed_word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.ch;
        s_tuser  <= {it.joined, it.start};
        s_tlast  <= it.fin;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (it.fin)
            spellings_done++;
        normalize_word(it);
        if (typed)
            path_expect.push_back(typed_word);
        else
            for (int k = 0; k < next_count; k++)
                path_expect.push_back(next_words[k]);
    endtask

    task automatic push_char(input logic [7:0] ch);
        spell_q.push_back('{ch, 1'b0, 1'b0, 1'b0});
    endtask

    // Build one spelling: mostly well-formed, some noise, some without finish
    task automatic make_spelling();
        int kind;
        int ncomp;
        int pick;
        int nlen;
        int roll;
        path_item_t it;
        spell_q.delete();
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(6, 1))
            begin
                it.ch     = 8'($urandom);
                it.start  = 1'($urandom_range(1));
                it.joined = 1'($urandom_range(1));
                it.fin    = ($urandom_range(99) < 25);
                spell_q.push_back(it);
            end
            return;
        end
        if ($urandom_range(1) != 0)
            push_char(SLASH_CHAR);
        ncomp = $urandom_range(4, 1);
        for (int c = 0; c < ncomp; c++)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                push_char(DOT_CHAR);
            else if (pick < 35)
            begin
                push_char(DOT_CHAR);
                push_char(DOT_CHAR);
            end
            else
            begin
                nlen = (pick < 43) ? $urandom_range(70, 20) : $urandom_range(8, 1);
                repeat (nlen)
                begin
                    roll = $urandom_range(99);
                    if (roll < 80)
                        push_char(8'($urandom_range(122, 97)));
                    else if (roll < 85)
                        push_char(DOT_CHAR);
                    else
                        push_char(8'($urandom_range(255)));
                end
            end
            if (c < ncomp - 1 || $urandom_range(99) < 30)
                repeat ($urandom_range(3, 1)) push_char(SLASH_CHAR);
        end
        it        = spell_q[0];
        it.start  = 1'b1;
        it.joined = ($urandom_range(99) < 35);
        spell_q[0] = it;
        // leave some spellings open so the next start discards them
        if (kind >= 20)
        begin
            if ($urandom_range(99) < 25)
                push_char(NUL_CHAR);
            it     = spell_q[spell_q.size() - 1];
            it.fin = 1'b1;
            spell_q[spell_q.size() - 1] = it;
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each output word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            words_checked++;
            if (m_tuser[0] == 1'b0)
                error_words++;
            if (path_expect.size() == 0)
                report_mismatch($sformatf("unexpected word byte=%h last=%b ok=%b",
                                          m_tdata, m_tlast, m_tuser[0]));
            else
            begin
                head_word = path_expect.pop_front();
                if (m_tdata !== head_word.pbyte)
                    report_mismatch($sformatf("path byte %h, want %h", m_tdata, head_word.pbyte));
                if (m_tlast !== head_word.last)
                    report_mismatch($sformatf("last %b, want %b", m_tlast, head_word.last));
                if (m_tuser[0] !== head_word.ok)
                    report_mismatch($sformatf("ok %b, want %b", m_tuser[0], head_word.ok));
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no word moved in %0d cycles, %0d words outstanding",
                     $time, STALL_LIMIT, path_expect.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        dir_row_t row;
        path_item_t it;
        idle_mode_t mode;
        int target;

        directed_rows = '{
            // finish right after reset: root only
            '{NUL_CHAR,   1'b0, 1'b0, 1'b1, 8'd1,  1'b1, SLASH_CHAR, 1'b1},
            '{SLASH_CHAR, 1'b1, 1'b0, 1'b1, 8'd1,  1'b1, SLASH_CHAR, 1'b1},
            // "a<FF>/./.." then an empty finish
            '{8'h61,      1'b1, 1'b0, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{8'hFF,      1'b0, 1'b0, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{SLASH_CHAR, 1'b0, 1'b0, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{DOT_CHAR,   1'b0, 1'b0, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{SLASH_CHAR, 1'b0, 1'b0, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{DOT_CHAR,   1'b0, 1'b0, 1'b0, 8'd2,  1'b0, 8'h00, 1'b0},
            '{NUL_CHAR,   1'b0, 1'b0, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0},
            // working directory, relative join, absolute join, unjoined relative
            '{SLASH_CHAR, 1'b1, 1'b0, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{8'h64,      1'b0, 1'b0, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0},
            '{8'h65,      1'b1, 1'b1, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0},
            '{SLASH_CHAR, 1'b1, 1'b1, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{8'h66,      1'b0, 1'b0, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0},
            '{8'h67,      1'b1, 1'b0, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0},
            // open component discarded by a joined start, zero byte inside a name
            '{8'h68,      1'b1, 1'b0, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{8'h6B,      1'b1, 1'b1, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{NUL_CHAR,   1'b0, 1'b0, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{8'h6E,      1'b0, 1'b0, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0},
            // overflow, error kept across a joined spelling, cleared by restart
            '{8'h7A,      1'b1, 1'b0, 1'b0, 8'd63, 1'b0, 8'h00, 1'b0},
            '{NUL_CHAR,   1'b0, 1'b0, 1'b1, 8'd1,  1'b1, 8'h00, 1'b0},
            '{8'h71,      1'b1, 1'b1, 1'b1, 8'd1,  1'b1, 8'h00, 1'b0},
            '{SLASH_CHAR, 1'b1, 1'b1, 1'b1, 8'd1,  1'b1, SLASH_CHAR, 1'b1},
            // full buffer, then "." and ".." on it
            '{8'h79,      1'b1, 1'b0, 1'b0, 8'd62, 1'b0, 8'h00, 1'b0},
            '{SLASH_CHAR, 1'b0, 1'b0, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{DOT_CHAR,   1'b0, 1'b0, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0},
            '{DOT_CHAR,   1'b1, 1'b1, 1'b0, 8'd1,  1'b0, 8'h00, 1'b0},
            '{DOT_CHAR,   1'b0, 1'b0, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0},
            // every flag set on a top byte
            '{8'hFF,      1'b1, 1'b1, 1'b1, 8'd1,  1'b0, 8'h00, 1'b0}
        };

        for (int m = 0; m < PATH_BYTES; m++)
            path_mem[m] = 8'h00;
        go_root();

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed table
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            for (int k = 0; k < row.reps; k++)
            begin
                it.ch     = row.ch;
                it.start  = row.start && (k == 0);
                it.joined = row.joined && (k == 0);
                it.fin    = row.fin && (k == row.reps - 1);
                send_word(it, row.typed, '{row.want_byte, 1'b1, row.want_ok});
            end
        end

        // Random spellings, one phase per idling pattern
        for (int p = 0; p < 4; p++)
        begin
            mode = idle_mode_t'(p);
            case (mode)
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 61; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default:       begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            // back up the output while the sender keeps pushing
            if (mode == IDLE_NONE)
                hold_req = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                make_spelling();
                foreach (spell_q[i])
                    send_word(spell_q[i], 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow time for any stray word
        while (path_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input words in %0d finished spellings, directed and random.",
                 items_sent, spellings_done);
        $display("Checked %0d path words, %0d of them overflow errors, %0d mismatches.",
                 words_checked, error_words, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
src/lpn_pkg.sv
src/lpn_ram.sv
src/lexical_path_normalizer.sv
bench/tb_top.sv
